// ----- rtl/core/vfd_pkg.sv -----
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types, codes and helpers of the block video frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vfd_pkg;

   localparam logic [15:0] CMD_SKIP  = 16'h7FFE;
   localparam logic [15:0] CMD_COPY  = 16'h7FFD;
   localparam logic [15:0] CMD_DIFF  = 16'h7FFF;
   localparam logic [6:0]  TILE_PIX  = 7'd64;

   // stream parser phase, one-hot
   typedef enum logic [10:0] {
      PH_CMD_LO     = 11'b00000000001,
      PH_CMD_HI     = 11'b00000000010,
      PH_COPY_LO    = 11'b00000000100,
      PH_COPY_HI    = 11'b00000001000,
      PH_DIFF_LO    = 11'b00000010000,
      PH_DIFF_HI    = 11'b00000100000,
      PH_DIFF_MASK  = 11'b00001000000,
      PH_OPCODE     = 11'b00010000000,
      PH_RAW        = 11'b00100000000,
      PH_FILL_COUNT = 11'b01000000000,
      PH_FILL_COLOR = 11'b10000000000
   } phase_type;

   // sequencer state, one-hot
   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_GEN    = 7'b0000100,
      S_REF    = 7'b0001000,
      S_EMIT   = 7'b0010000,
      S_DONE   = 7'b0100000,
      S_SWEEP  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load_pix;
      logic load_ref;
   } agen_ctrl_type;

   // clamp a run length to the pixels left in the block
   function automatic logic [6:0] clamp_run(input logic [7:0] n, input logic [6:0] left);
      logic [6:0] r;
      if (n < {1'b0, left}) begin
         r = n[6:0];
      end else begin
         r = left;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vfd_ram.sv -----
// ----------------------------------------------------------------------------
// vfd_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/vfd_agen.sv -----
// ----------------------------------------------------------------------------
// vfd_agen
// Shared address unit: pixel address, then offset reference address and
// frame bounds check.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_agen #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 200,
   localparam int FP = FRAME_WIDTH * FRAME_HEIGHT,
   localparam int AW = $clog2(FP),
   localparam int PW = (AW > 16) ? AW : 16
) (
   input  wire logic                  clock,
   input  wire vfd_pkg::agen_ctrl_type ctl,
   input  wire logic [AW-1:0]         tile_base,
   input  wire logic [6:0]            pix_index,
   input  wire logic [15:0]           offset,
   output logic      [PW-1:0]         pix_address_ff,
   output logic      [AW-1:0]         ref_address,
   output logic                       ref_ok_ff
);
   import vfd_pkg::*;

   localparam int RW = PW + 2;

   logic [PW-1:0] pix_in;
   logic [RW-1:0] ref_sum;
   logic          ref_ok_in;

   assign pix_in = PW'(tile_base) + PW'(pix_index[5:3]) * PW'(FRAME_WIDTH)
                 + PW'(pix_index[2:0]);

   assign ref_sum = {2'b00, pix_address_ff} + {{(RW-16){offset[15]}}, offset};
   assign ref_ok_in = !ref_sum[RW-1] && (ref_sum < RW'(FP));
   assign ref_address = ref_sum[AW-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load_pix) begin
         pix_address_ff <= pix_in;
      end
      if (ctl.load_ref) begin
         ref_ok_ff <= ref_ok_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/block_video_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// block_video_frame_decoder_top
// Decodes a byte stream of 8x8 block commands into pixel writes.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req_    | in        | stream_byte
//  rsp_    | out       | pixel_address, pixel_value, run_last, frame_done
//
//  A byte is taken only in the idle state. Each pixel that it writes goes
//  through an address step, a reference read and a write (S_GEN, S_REF,
//  S_EMIT), as the address unit and the reference frame read port are
//  shared. A masked diff pixel is passed over in S_GEN without a write.
//  After reset a clearing pass zeroes both frames. At frame end the
//  current frame is copied into the reference frame. req_ready is low
//  during both. A stalled result holds in the output register and holds
//  the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module block_video_frame_decoder_top #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 200
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_stream_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [15:0] rsp_pixel_address,
   output logic      [7:0]  rsp_pixel_value,
   output logic             rsp_run_last,
   output logic             rsp_frame_done
);
   import vfd_pkg::*;

   localparam int FP  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW  = $clog2(FP);
   localparam int PW  = (AW > 16) ? AW : 16;
   localparam int TX  = FRAME_WIDTH / 8;
   localparam int TY  = FRAME_HEIGHT / 8;
   localparam int BXW = (TX > 1) ? $clog2(TX) : 1;
   localparam int BYW = (TY > 1) ? $clog2(TY) : 1;

   // sequencer and parser state
   state_type      state_ff;
   phase_type      phase_ff;
   logic [15:0]    held_ff;
   logic [6:0]     p_ff;
   logic [6:0]     run_ff;
   logic [2:0]     row_ff;
   logic [6:0]     cnt_ff;
   logic [7:0]     en_ff;
   logic [7:0]     val_ff;
   logic           src_ref_ff;
   logic           diff_ff;
   logic           fin_ff;

   // tile position
   logic [BXW-1:0] bx_ff;
   logic [BYW-1:0] by_ff;
   logic [AW-1:0]  tile_base_ff;
   logic [AW-1:0]  row_start_ff;

   // clear and copy sweep
   logic [AW-1:0]  a_ff;
   logic [AW-1:0]  a_d_ff;
   logic           sw_v_ff;

   // output register
   logic           rsp_valid_ff;
   logic [15:0]    rsp_addr_ff;
   logic [7:0]     rsp_val_ff;
   logic           rsp_last_ff;
   logic           rsp_done_ff;

   // datapath
   agen_ctrl_type  actl;
   logic [PW-1:0]  pix_address;
   logic [AW-1:0]  ref_address;
   logic           ref_ok;
   logic [7:0]     ref_rdata;
   logic [7:0]     cur_rdata;
   logic           last_blk;
   logic           accept;
   logic           out_free;
   logic           emit;
   logic           pix_last;
   logic [7:0]     emit_val;

   // decode of the accepted byte
   logic [15:0]    d_held;
   phase_type      d_phase;
   logic [6:0]     d_p;
   logic [6:0]     d_cnt;
   logic [6:0]     d_run;
   logic [2:0]     d_row;
   logic [7:0]     d_en;
   logic           d_src_ref;
   logic           d_diff;
   logic           d_fin;
   logic [6:0]     left;
   logic [6:0]     n_raw;
   logic [6:0]     n_quad;
   logic [7:0]     p_plus;
   logic [15:0]    cmd_word;

   assign last_blk = (bx_ff == BXW'(TX - 1)) && (by_ff == BYW'(TY - 1));
   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (state_ff == S_EMIT) && out_free;
   assign pix_last = diff_ff ? (en_ff[7:1] == 7'd0) : (cnt_ff == 7'd1);
   assign emit_val = src_ref_ff ? (ref_ok ? ref_rdata : 8'd0) : val_ff;

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_pixel_value   = rsp_val_ff;
   assign rsp_run_last      = rsp_last_ff;
   assign rsp_frame_done    = rsp_done_ff;

   assign left     = TILE_PIX - p_ff;
   assign n_raw    = clamp_run({1'b0, req_stream_byte[7:1]}, left);
   assign n_quad   = clamp_run({2'b00, req_stream_byte[7:2]}, left);
   assign cmd_word = {req_stream_byte, held_ff[7:0]};

   // Decode one stream byte: next phase, and the pixel run it starts.
   always_comb begin
      d_held    = held_ff;
      d_phase   = phase_ff;
      d_p       = p_ff;
      d_cnt     = 7'd0;
      d_run     = run_ff;
      d_row     = row_ff;
      d_en      = 8'hFF;
      d_src_ref = 1'b0;
      d_diff    = 1'b0;
      d_fin     = 1'b0;
      p_plus    = 8'd0;
      case (phase_ff)
         PH_CMD_HI: begin
            d_held = cmd_word;
            d_p    = 7'd0;
            if (cmd_word == CMD_SKIP) begin
               d_fin = 1'b1;
            end else if (cmd_word == CMD_COPY) begin
               d_phase = PH_COPY_LO;
            end else if (cmd_word == CMD_DIFF) begin
               d_phase = PH_DIFF_LO;
            end else begin
               d_phase = PH_OPCODE;
            end
         end
         PH_COPY_LO: begin
            d_held  = {8'd0, req_stream_byte};
            d_phase = PH_COPY_HI;
         end
         PH_DIFF_LO: begin
            d_held  = {8'd0, req_stream_byte};
            d_phase = PH_DIFF_HI;
         end
         PH_COPY_HI: begin
            d_held    = cmd_word;
            d_p       = 7'd0;
            d_cnt     = TILE_PIX;
            d_src_ref = 1'b1;
            d_fin     = 1'b1;
         end
         PH_DIFF_HI: begin
            d_held  = cmd_word;
            d_row   = 3'd0;
            d_phase = PH_DIFF_MASK;
         end
         PH_DIFF_MASK: begin
            d_p       = {1'b0, row_ff, 3'd0};
            d_cnt     = 7'd8;
            d_en      = ~req_stream_byte;
            d_diff    = 1'b1;
            d_src_ref = 1'b1;
            d_fin     = (row_ff == 3'd7);
            d_row     = row_ff + 3'd1;
         end
         PH_OPCODE: begin
            if (!req_stream_byte[0]) begin
               if (n_raw != 7'd0) begin
                  d_run   = n_raw;
                  d_phase = PH_RAW;
               end
            end else if (req_stream_byte == 8'd1) begin
               d_phase = PH_FILL_COUNT;
            end else if (req_stream_byte[1]) begin
               d_cnt     = n_quad;
               d_src_ref = 1'b1;
               p_plus    = {1'b0, p_ff} + {1'b0, n_quad};
               d_fin     = (p_plus >= 8'd64);
            end else begin
               p_plus = {1'b0, p_ff} + {1'b0, n_quad};
               d_p    = p_plus[6:0];
               d_fin  = (p_plus >= 8'd64);
            end
         end
         PH_RAW: begin
            d_cnt = 7'd1;
            d_run = run_ff - 7'd1;
            if (run_ff == 7'd1) begin
               p_plus  = {1'b0, p_ff} + 8'd1;
               d_fin   = (p_plus >= 8'd64);
               d_phase = PH_OPCODE;
            end
         end
         PH_FILL_COUNT: begin
            d_run   = clamp_run(req_stream_byte, left);
            d_phase = PH_FILL_COLOR;
         end
         PH_FILL_COLOR: begin
            d_cnt   = run_ff;
            d_run   = 7'd0;
            p_plus  = {1'b0, p_ff} + {1'b0, run_ff};
            d_fin   = (p_plus >= 8'd64);
            d_phase = PH_OPCODE;
         end
         default: begin
            // command low byte
            d_held  = {8'd0, req_stream_byte};
            d_phase = PH_CMD_HI;
         end
      endcase
   end

   always_comb begin
      actl.load_pix = (state_ff == S_GEN);
      actl.load_ref = (state_ff == S_REF);
   end

   vfd_agen #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_agen (
      .clock          (clock),
      .ctl            (actl),
      .tile_base      (tile_base_ff),
      .pix_index      (p_ff),
      .offset         (held_ff),
      .pix_address_ff (pix_address),
      .ref_address    (ref_address),
      .ref_ok_ff      (ref_ok)
   );

   // current frame: written per pixel and zeroed by the clear, read by the frame-end sweep
   vfd_ram #(.WIDTH(8), .DEPTH(FP)) u_cur_ram (
      .clock      (clock),
      .wr_en      ((state_ff == S_CLEAR) || emit),
      .wr_addr    ((state_ff == S_CLEAR) ? a_ff : pix_address[AW-1:0]),
      .wr_data    ((state_ff == S_CLEAR) ? 8'd0 : emit_val),
      .rd_addr    (a_ff),
      .rd_data_ff (cur_rdata)
   );

   // reference frame: read at offset addresses, written by clear and sweep
   vfd_ram #(.WIDTH(8), .DEPTH(FP)) u_ref_ram (
      .clock      (clock),
      .wr_en      ((state_ff == S_CLEAR) || sw_v_ff),
      .wr_addr    ((state_ff == S_CLEAR) ? a_ff : a_d_ff),
      .wr_data    ((state_ff == S_CLEAR) ? 8'd0 : cur_rdata),
      .rd_addr    (ref_address),
      .rd_data_ff (ref_rdata)
   );

   // Sequencer: clear both frames after reset; parse a byte, step through its pixels, then commit; sweep at frame end.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         phase_ff     <= PH_CMD_LO;
         held_ff      <= 16'd0;
         p_ff         <= 7'd0;
         run_ff       <= 7'd0;
         row_ff       <= 3'd0;
         cnt_ff       <= 7'd0;
         en_ff        <= 8'hFF;
         src_ref_ff   <= 1'b0;
         diff_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         bx_ff        <= '0;
         by_ff        <= '0;
         tile_base_ff <= '0;
         row_start_ff <= '0;
         a_ff         <= '0;
         sw_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load on a pixel write, drop once the transaction is taken
         rsp_valid_ff <= emit || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            S_CLEAR: begin
               if (a_ff == AW'(FP - 1)) begin
                  a_ff     <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  a_ff <= a_ff + AW'(1);
               end
            end
            S_IDLE: begin
               if (accept) begin
                  held_ff    <= d_held;
                  phase_ff   <= d_phase;
                  p_ff       <= d_p;
                  cnt_ff     <= d_cnt;
                  run_ff     <= d_run;
                  row_ff     <= d_row;
                  en_ff      <= d_en;
                  val_ff     <= req_stream_byte;
                  src_ref_ff <= d_src_ref;
                  diff_ff    <= d_diff;
                  fin_ff     <= d_fin;
                  state_ff   <= S_GEN;
               end
            end
            S_GEN: begin
               if (cnt_ff == 7'd0) begin
                  state_ff <= S_DONE;
               end else if (en_ff[0]) begin
                  state_ff <= S_REF;
               end else begin
                  // masked pixel: advance without a write
                  p_ff   <= p_ff + 7'd1;
                  cnt_ff <= cnt_ff - 7'd1;
                  en_ff  <= {!diff_ff, en_ff[7:1]};
               end
            end
            S_REF: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_addr_ff  <= pix_address[15:0];
                  rsp_val_ff   <= emit_val;
                  rsp_last_ff  <= pix_last;
                  rsp_done_ff  <= pix_last && fin_ff && last_blk;
                  p_ff         <= p_ff + 7'd1;
                  cnt_ff       <= cnt_ff - 7'd1;
                  en_ff        <= {!diff_ff, en_ff[7:1]};
                  state_ff     <= pix_last ? S_DONE : S_GEN;
               end
            end
            S_DONE: begin
               state_ff <= (fin_ff && last_blk) ? S_SWEEP : S_IDLE;
               if (fin_ff) begin
                  p_ff     <= 7'd0;
                  run_ff   <= 7'd0;
                  row_ff   <= 3'd0;
                  phase_ff <= PH_CMD_LO;
                  if (last_blk) begin
                     bx_ff        <= '0;
                     by_ff        <= '0;
                     tile_base_ff <= '0;
                     row_start_ff <= '0;
                     a_ff         <= '0;
                  end else if (bx_ff == BXW'(TX - 1)) begin
                     bx_ff        <= '0;
                     by_ff        <= by_ff + BYW'(1);
                     row_start_ff <= row_start_ff + AW'(8 * FRAME_WIDTH);
                     tile_base_ff <= row_start_ff + AW'(8 * FRAME_WIDTH);
                  end else begin
                     bx_ff        <= bx_ff + BXW'(1);
                     tile_base_ff <= tile_base_ff + AW'(8);
                  end
               end
            end
            S_SWEEP: begin
               // read current at a_ff, write reference at that address in the next cycle
               a_d_ff <= a_ff;
               if (sw_v_ff && (a_d_ff == AW'(FP - 1))) begin
                  sw_v_ff  <= 1'b0;
                  a_ff     <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  sw_v_ff <= 1'b1;
                  if (a_ff != AW'(FP - 1)) begin
                     a_ff <= a_ff + AW'(1);
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_last_ff)
      else $error("frame_done without run_last");

   a_pix_in_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> p_ff < TILE_PIX)
      else $error("pixel index past block end");

   a_frame_sweep: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && fin_ff && last_blk |=> state_ff == S_SWEEP)
      else $error("frame end without reference copy");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted pixel lost");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block video frame decoder. A short directed
// byte stream walks the mixed, copy and diff block modes and edge cases, then random
// well-formed blocks with some noise bytes run through a full frame end and
// into a second frame. Each accepted byte goes through a local decoder model.
// Every pixel write is compared in order against that model's expected
// writes, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vfd_pkg::*;

   localparam int FW       = 320;
   localparam int FH       = 200;
   localparam int NPIX     = FW * FH;
   localparam int NBLK     = (FW / 8) * (FH / 8);
   localparam int RAND_LEN = 500;

   // command bytes (little endian halves of the package codes)
   localparam logic [7:0] CMD_LO_COPY = CMD_COPY[7:0];
   localparam logic [7:0] CMD_LO_DIFF = CMD_DIFF[7:0];
   localparam logic [7:0] CMD_HI_ALL  = CMD_SKIP[15:8];
   localparam logic [7:0] OP_FILL     = 8'h01;

   typedef struct {
      logic [15:0] addr;
      logic [7:0]  value;
      logic        last;
      logic        fdone;
   } pixel_write_type;

   typedef struct {
      logic [7:0]  data;
      logic        pin;
      logic [15:0] addr;
      logic [7:0]  value;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_pixel_address;
   logic [7:0]  rsp_pixel_value;
   logic        rsp_run_last;
   logic        rsp_frame_done;

   int errors = 0;
   bit quiet  = 1'b0;   // no idling on either side while set

   // local decoder state
   logic [7:0]   ref_frame [NPIX];
   logic [7:0]   live_frame [NPIX];
   int           blk_idx;
   phase_type    phase;
   logic [15:0]  held;
   int           px_done;
   int           run_left;
   logic [7:0]   fill_col;
   int           mask_row;
   bit           frame_ended;
   int           frames_seen;
   pixel_write_type step_writes [$];
   pixel_write_type expected_writes [$];
   logic [7:0]   byte_q [$];

   // directed stream: mixed, copy out of frame, diff, and a mixed block of
   // zero raw, single copy and a clamped skip
   stim_row_type dir_tab [29] = '{
      '{8'h00, 0, 16'd0, 8'h00}, '{8'h00, 0, 16'd0, 8'h00},
      '{8'h04, 0, 16'd0, 8'h00}, '{8'hFF, 1, 16'd0, 8'hFF},
      '{8'h00, 1, 16'd1, 8'h00}, '{OP_FILL, 0, 16'd0, 8'h00},
      '{8'hFF, 0, 16'd0, 8'h00}, '{8'hAA, 1, 16'd2, 8'hAA},
      '{CMD_LO_COPY, 0, 16'd0, 8'h00}, '{CMD_HI_ALL, 0, 16'd0, 8'h00},
      '{8'h00, 0, 16'd0, 8'h00}, '{8'h80, 1, 16'd8, 8'h00},
      '{CMD_LO_DIFF, 0, 16'd0, 8'h00}, '{CMD_HI_ALL, 0, 16'd0, 8'h00},
      '{8'h00, 0, 16'd0, 8'h00}, '{8'h00, 0, 16'd0, 8'h00},
      '{8'h00, 1, 16'd16, 8'h00}, '{8'hFF, 0, 16'd0, 8'h00},
      '{8'h55, 1, 16'd657, 8'h00}, '{8'hAA, 0, 16'd0, 8'h00},
      '{8'h0F, 0, 16'd0, 8'h00}, '{8'hF0, 0, 16'd0, 8'h00},
      '{8'h7E, 0, 16'd0, 8'h00}, '{8'h81, 0, 16'd0, 8'h00},
      '{8'h00, 0, 16'd0, 8'h00}, '{8'h00, 0, 16'd0, 8'h00},
      '{8'h00, 0, 16'd0, 8'h00}, '{8'h07, 1, 16'd24, 8'h00},
      '{8'hFD, 0, 16'd0, 8'h00}
   };

   block_video_frame_decoder_top #(
      .FRAME_WIDTH (FW),
      .FRAME_HEIGHT(FH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_address(rsp_pixel_address),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_done   (rsp_frame_done)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Decoder model
   // ---------------------------------------------------------------------
   function automatic int block_pixel_addr(int p);
      int bx;
      int by;
      bx = blk_idx % (FW / 8);
      by = blk_idx / (FW / 8);
      return by * 8 * FW + bx * 8 + (p / 8) * FW + (p % 8);
   endfunction

   // reference read at the held signed offset; outside the frame reads 0
   function automatic logic [7:0] ref_pixel(int p);
      int a;
      a = block_pixel_addr(p) + int'($signed(held));
      if (a < 0 || a >= NPIX) return 8'h00;
      return ref_frame[a];
   endfunction

   function automatic void write_pixel(int p, logic [7:0] v);
      pixel_write_type w;
      int a;
      a = block_pixel_addr(p);
      if (a >= 0 && a < NPIX) live_frame[a] = v;
      w.addr  = a[15:0];
      w.value = v;
      w.last  = 1'b0;
      w.fdone = 1'b0;
      step_writes.push_back(w);
   endfunction

   function automatic int clamp_len(int n);
      return (n < 64 - px_done) ? n : 64 - px_done;
   endfunction

   function automatic void close_block();
      blk_idx++;
      px_done  = 0;
      run_left = 0;
      mask_row = 0;
      phase    = PH_CMD_LO;
      if (blk_idx >= NBLK) begin
         for (int i = 0; i < NPIX; i++) ref_frame[i] = live_frame[i];
         blk_idx     = 0;
         frame_ended = 1'b1;
         frames_seen++;
      end
   endfunction

   function automatic void run_done();
      if (px_done >= 64) close_block();
      else phase = PH_OPCODE;
   endfunction

   function automatic void decode_opcode(logic [7:0] op);
      int n;
      if (!op[0]) begin
         n = clamp_len(op >> 1);
         if (n == 0) run_done();
         else begin
            run_left = n;
            phase    = PH_RAW;
         end
      end else if (op == OP_FILL) begin
         phase = PH_FILL_COUNT;
      end else if (op[1:0] == 2'b11) begin
         n = clamp_len(op >> 2);
         for (int i = 0; i < n; i++) begin
            write_pixel(px_done, ref_pixel(px_done));
            px_done++;
         end
         run_done();
      end else begin
         px_done += clamp_len(op >> 2);
         run_done();
      end
   endfunction

   function automatic void reset_decoder();
      for (int i = 0; i < NPIX; i++) begin
         ref_frame[i]  = 8'h00;
         live_frame[i] = 8'h00;
      end
      blk_idx     = 0;
      phase       = PH_CMD_LO;
      held        = 16'h0000;
      px_done     = 0;
      run_left    = 0;
      fill_col    = 8'h00;
      mask_row    = 0;
      frames_seen = 0;
   endfunction

   // advance the model by one accepted byte; queue the writes it causes
   function automatic void decode_byte(stim_row_type row);
      logic [7:0] b;
      int p;
      b = row.data;
      step_writes.delete();
      frame_ended = 1'b0;
      case (phase)
         PH_CMD_HI: begin
            held    = {b, held[7:0]};
            px_done = 0;
            if (held == CMD_SKIP) close_block();
            else if (held == CMD_COPY) phase = PH_COPY_LO;
            else if (held == CMD_DIFF) phase = PH_DIFF_LO;
            else phase = PH_OPCODE;
         end
         PH_COPY_LO: begin
            held  = {8'h00, b};
            phase = PH_COPY_HI;
         end
         PH_DIFF_LO: begin
            held  = {8'h00, b};
            phase = PH_DIFF_HI;
         end
         PH_COPY_HI: begin
            held = {b, held[7:0]};
            for (int i = 0; i < 64; i++) write_pixel(i, ref_pixel(i));
            close_block();
         end
         PH_DIFF_HI: begin
            held     = {b, held[7:0]};
            mask_row = 0;
            phase    = PH_DIFF_MASK;
         end
         PH_DIFF_MASK: begin
            for (int i = 0; i < 8; i++) begin
               if (!b[i]) begin
                  p = mask_row * 8 + i;
                  write_pixel(p, ref_pixel(p));
               end
            end
            if (mask_row >= 7) close_block();
            else mask_row++;
         end
         PH_OPCODE: decode_opcode(b);
         PH_RAW: begin
            write_pixel(px_done, b);
            px_done++;
            if (run_left > 0) run_left--;
            if (run_left == 0) run_done();
         end
         PH_FILL_COUNT: begin
            run_left = clamp_len(b);
            phase    = PH_FILL_COLOR;
         end
         PH_FILL_COLOR: begin
            fill_col = b;
            while (run_left > 0) begin
               write_pixel(px_done, fill_col);
               px_done++;
               run_left--;
            end
            run_done();
         end
         default: begin
            held  = {8'h00, b};
            phase = PH_CMD_HI;
         end
      endcase
      if (step_writes.size() > 0) begin
         step_writes[$].last  = 1'b1;
         step_writes[$].fdone = frame_ended;
      end
      // pinned rows: the typed-in first write must agree with the model
      if (row.pin) begin
         if (step_writes.size() == 0) begin
            $display("%0t: pinned row %h: expected addr %0d value %h, actual no write",
                     $realtime, b, row.addr, row.value);
            errors++;
         end else if (step_writes[0].addr != row.addr
                      || step_writes[0].value != row.value) begin
            $display("%0t: pinned row %h: expected addr %0d value %h, actual addr %0d value %h",
                     $realtime, b, row.addr, row.value, step_writes[0].addr,
                     step_writes[0].value);
            errors++;
         end
      end
      foreach (step_writes[i]) expected_writes.push_back(step_writes[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Stream generator
   // ---------------------------------------------------------------------
   function automatic logic [15:0] pick_offset();
      int r;
      logic [15:0] o;
      r = $urandom_range(0, 99);
      if (r < 60) o = 16'($urandom_range(0, 1400) - 700);
      else if (r < 80) o = 16'h0000;
      else o = 16'($urandom);
      return o;
   endfunction

   function automatic void push_word(logic [15:0] w);
      byte_q.push_back(w[7:0]);
      byte_q.push_back(w[15:8]);
   endfunction

   function automatic void gen_mixed();
      logic [15:0] o;
      int left;
      int n;
      int k;
      o = pick_offset();
      if (o == CMD_SKIP || o == CMD_COPY || o == CMD_DIFF) o = 16'h0000;
      push_word(o);
      left = 64;
      while (left > 0) begin
         k = $urandom_range(0, 99);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
         if (k < 30) begin
            if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 127);
            byte_q.push_back(8'(n << 1));
            n = (n < left) ? n : left;
            repeat (n) byte_q.push_back(8'($urandom));
         end else if (k < 55) begin
            if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 1) ? 255 : 0;
            byte_q.push_back(OP_FILL);
            byte_q.push_back(8'(n));
            byte_q.push_back(8'($urandom));
         end else if (k < 80) begin
            byte_q.push_back(8'((n << 2) | 3));
         end else begin
            if (n == 0) n = 1;
            byte_q.push_back(8'((n << 2) | 1));
         end
         left -= (n < left) ? n : left;
      end
   endfunction

   // queue one block; bytes off the block grid are resynchronized by noise
   function automatic void gen_block(bit allow_noise);
      int r;
      r = $urandom_range(0, 99);
      if (phase != PH_CMD_LO) begin
         byte_q.push_back(8'($urandom));
      end else if (allow_noise && r < 4) begin
         repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom));
      end else if (r < 18) begin
         push_word(CMD_SKIP);
      end else if (r < 33) begin
         push_word(CMD_COPY);
         push_word(pick_offset());
      end else if (r < 50) begin
         push_word(CMD_DIFF);
         push_word(pick_offset());
         repeat (8) byte_q.push_back(8'($urandom));
      end else begin
         gen_mixed();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // hold the transaction until accepted, then advance the model
   task automatic send_byte(stim_row_type row);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= row.data;
      do @(posedge clock); while (!req_ready);
      decode_byte(row);
   endtask

   task automatic send_queued();
      stim_row_type row;
      row.pin   = 1'b0;
      row.addr  = 16'h0000;
      row.value = 8'h00;
      while (byte_q.size() > 0) begin
         row.data = byte_q.pop_front();
         send_byte(row);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_writes.size() > 0) @(posedge clock);
   endtask

   // result side: random stalls, drop them entirely while quiet
   int stall_cnt = 0;
   always @(posedge clock) begin
      if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_cnt <= idle_len();
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Result check: compare each transaction against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_write_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_writes.size() == 0) begin
            $display("%0t: unexpected write addr %0d value %h", $realtime,
                     rsp_pixel_address, rsp_pixel_value);
            errors++;
         end else begin
            e = expected_writes.pop_front();
            if (rsp_pixel_address !== e.addr) begin
               $display("%0t: pixel_address expected %0d actual %0d", $realtime,
                        e.addr, rsp_pixel_address);
               errors++;
            end
            if (rsp_pixel_value !== e.value) begin
               $display("%0t: pixel_value expected %h actual %h", $realtime,
                        e.value, rsp_pixel_value);
               errors++;
            end
            if (rsp_run_last !== e.last) begin
               $display("%0t: run_last expected %b actual %b", $realtime,
                        e.last, rsp_run_last);
               errors++;
            end
            if (rsp_frame_done !== e.fdone) begin
               $display("%0t: frame_done expected %b actual %b", $realtime,
                        e.fdone, rsp_frame_done);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int sent;
      reset_decoder();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table, checked through the model and the pinned rows
      foreach (dir_tab[i]) send_byte(dir_tab[i]);

      // hold off until every expected write is back
      drain();

      // random blocks, with a stretch of no idling in the middle
      sent = 0;
      while (sent < RAND_LEN) begin
         quiet = (sent >= 200 && sent < 260);
         gen_block(1'b1);
         sent += byte_q.size();
         send_queued();
      end
      quiet = 1'b0;

      // skip through the rest of the frame so the reference gets updated
      while (frames_seen == 0) begin
         gen_block(1'b0);
         if (byte_q.size() > 1 && $urandom_range(0, 19) != 0) begin
            byte_q.delete();
            push_word(CMD_SKIP);
         end
         send_queued();
      end

      // second frame: straight copies read back the new reference
      repeat (4) begin
         push_word(CMD_COPY);
         push_word(16'h0000);
         send_queued();
      end
      repeat (20) begin
         gen_block(1'b1);
         send_queued();
      end

      drain();
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #50ms;
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
